// File: rtl/bal_pkg.sv
package bal_pkg;

  // Default capacity of the list.
  localparam int unsigned LIST_DEPTH_DEF = 16;

  // Width of one stored entry.
  localparam int unsigned DATA_W = 32;

  // Request codes.
  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_FIND      = 2'd2,
    OP_READ_LAST = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // Action broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_COMPARE
  } cell_op_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CELL,
    S_DONE
  } state_e;

  // Broadcast control to the cells.
  typedef struct packed {
    cell_op_e          op;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

  // Request transaction payload.
  typedef struct packed {
    logic [1:0]               opcode;
    logic [4:0]               position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  // Result transaction payload.
  typedef struct packed {
    logic [2:0]               status;
    logic [3:0]               found_index;
    logic signed [DATA_W-1:0] read_value;
    logic [4:0]               entry_count;
    logic                     is_empty_flag;
  } rsp_t;

endpackage

// File: rtl/bal_cell.sv
module bal_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned CMP_W    = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bal_pkg::cell_ctl_t      ctl_i,
  input  logic [CMP_W-1:0]        pos_i,
  input  logic [CMP_W-1:0]        cnt_i,
  input  logic [bal_pkg::DATA_W-1:0] prev_i,
  input  logic [bal_pkg::DATA_W-1:0] next_i,
  output logic [bal_pkg::DATA_W-1:0] data_o,
  output logic                    match_o
);
  import bal_pkg::*;

  localparam logic [CMP_W-1:0] Idx     = CMP_W'(CELL_IDX);
  localparam logic [CMP_W-1:0] IdxNext = CMP_W'(CELL_IDX + 1);

  logic [DATA_W-1:0] data_d, data_q;
  logic              match_d, match_q;

  // Each cell loads the new value, takes its left or right neighbor's
  // entry, or compares its entry against the searched value.
  always_comb begin
    data_d  = data_q;
    match_d = match_q;
    case (ctl_i.op)
      CELL_INSERT: begin
        if (Idx == pos_i) begin
          data_d = ctl_i.value;
        end else if ((Idx > pos_i) && (Idx <= cnt_i)) begin
          data_d = prev_i;
        end
      end
      CELL_REMOVE: begin
        if ((Idx >= pos_i) && (IdxNext < cnt_i)) begin
          data_d = next_i;
        end
      end
      CELL_COMPARE: begin
        match_d = (data_q == ctl_i.value) && (Idx < cnt_i);
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  // Entry storage has no reset; only written entries are ever read.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// File: rtl/bounded_array_list_engine.sv
// Channel  | Direction | Handshake               | Payload
// request  | in        | in_valid_i / in_ready_o | in_data_i  (req_t)
// result   | out       | out_valid_o / out_ready_i | out_data_o (rsp_t)
//
// Each request passes through three steps: capture, a step in which every
// cell of the chain shifts or compares at once, and a step that encodes the
// first match and loads the output register. Reset clears the count and the
// handshake state; entries hold no reset value. A stalled result holds the
// block in its final step until the output register is free.
module bounded_array_list_engine #(
  parameter int unsigned LIST_DEPTH = bal_pkg::LIST_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bal_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bal_pkg::rsp_t out_data_o
);
  import bal_pkg::*;

  localparam int unsigned IDX_W = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;

  state_e            state_d, state_q;
  req_t              req_d, req_q;
  logic [CNT_W-1:0]  count_d, count_q;
  status_e           status_d, status_q;
  logic [DATA_W-1:0] rd_d, rd_q;
  rsp_t              out_d, out_q;
  logic              out_valid_d, out_valid_q;

  cell_ctl_t         cell_ctl;
  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic [DATA_W-1:0] data_w [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match_w;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  last_idx;
  logic              hit_any;
  logic [IDX_W-1:0]  hit_idx;

  assign pos_ext  = CMP_W'(req_q.position);
  assign cnt_ext  = CMP_W'(count_q);
  assign cnt_m1   = count_q - CNT_W'(1);
  assign last_idx = cnt_m1[IDX_W-1:0];

  // Chain of cells, each handing its entry to both neighbors.
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = cell_ctl.value;
    end else begin : g_mid_prev
      assign prev_w = data_w[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_next
      assign next_w = data_w[g+1];
    end
    bal_cell #(
      .CELL_IDX(g),
      .CMP_W   (CMP_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl),
      .pos_i  (pos_ext),
      .cnt_i  (cnt_ext),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (data_w[g]),
      .match_o(match_w[g])
    );
  end

  // First matching position from the registered compare flags.
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (match_w[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Next state, cell control and result assembly.
  always_comb begin
    state_d        = state_q;
    req_d          = req_q;
    count_d        = count_q;
    status_d       = status_q;
    rd_d           = rd_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    in_ready_o     = 1'b0;
    cell_ctl.op    = CELL_HOLD;
    cell_ctl.value = DATA_W'(req_q.value);
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_CELL;
        end
      end
      S_CELL: begin
        status_d = ST_OK;
        rd_d     = '0;
        case (op_e'(req_q.opcode))
          OP_INSERT: begin
            if (count_q == CNT_W'(LIST_DEPTH)) begin
              status_d = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
              status_d = ST_BADPOS;
            end else begin
              cell_ctl.op = CELL_INSERT;
              count_d     = count_q + CNT_W'(1);
            end
          end
          OP_REMOVE: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
              status_d = ST_BADPOS;
            end else begin
              cell_ctl.op = CELL_REMOVE;
              count_d     = cnt_m1;
            end
          end
          OP_FIND: begin
            cell_ctl.op = CELL_COMPARE;
          end
          OP_READ_LAST: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              rd_d = data_w[last_idx];
            end
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status        = 3'(status_q);
          out_d.found_index   = '0;
          out_d.read_value    = rd_q;
          out_d.entry_count   = 5'(count_q);
          out_d.is_empty_flag = (count_q == '0);
          if (op_e'(req_q.opcode) == OP_FIND) begin
            out_d.status = hit_any ? 3'(ST_OK) : 3'(ST_NOTFOUND);
            if (hit_any) begin
              out_d.found_index = 4'(hit_idx);
            end
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
